// ===== rtl/core/chord_tone_synthesizer_assert.svh =====
// ----------------------------------------------------------------------------
// Chord tone synthesizer assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CHORD_TONE_SYNTHESIZER_ASSERT_SVH
`define CHORD_TONE_SYNTHESIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSYN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSYN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/csyn_pkg.sv =====
// ----------------------------------------------------------------------------
// Chord tone synthesizer package
// Word types, control register codes and fixed field widths.
// ----------------------------------------------------------------------------
package csyn_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int VOLUME_W  = 15;
   localparam int SILENCE_W = 16;
   localparam int LENGTH_W  = 16;
   localparam int STEP_W    = 32;
   localparam int CSR_W     = 16;
   localparam int VOICES    = 3;

   localparam logic [VOLUME_W-1:0]  VOLUME_RESET  = 15'd3000;
   localparam logic [SILENCE_W-1:0] SILENCE_RESET = 16'd100;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_VOLUME  = 1'b0,
      CSR_SILENCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type              operation;
      logic [STEP_W-1:0]   step_first;
      logic [STEP_W-1:0]   step_second;
      logic [STEP_W-1:0]   step_third;
      logic [LENGTH_W-1:0] note_length;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       note_over;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic gate;
      logic over;
   } stage_flags_type;

endpackage

// ===== rtl/core/csyn_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Sine table
// Q1.15 sine over one full turn, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module csyn_sine_rom
   import csyn_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int AddrW = $clog2(TABLE_DEPTH)
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [AddrW-1:0]           addr,
   output logic signed [SAMPLE_W-1:0] rd_data_ff
);

   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
   localparam logic [63:0] OneQ30    = 64'd1073741824;
   localparam logic [63:0] Q15Max    = 64'd32767;

   // Angle is folded into the first quarter turn and a Taylor series
   // to the thirteenth power is evaluated in Q1.30.
   function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [63:0] i);
      logic [63:0] t, quad, rem, r, x, x2, term, s, q15;
      t    = i << 2;
      quad = t / TABLE_DEPTH;
      rem  = t % TABLE_DEPTH;
      r    = quad[0] ? (64'(TABLE_DEPTH) - rem) : rem;
      x    = (r * HalfPiQ30) / TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = OneQ30;
      term = OneQ30 - (((x2 * term) >> 30) / 156);
      term = OneQ30 - (((x2 * term) >> 30) / 110);
      term = OneQ30 - (((x2 * term) >> 30) / 72);
      term = OneQ30 - (((x2 * term) >> 30) / 42);
      term = OneQ30 - (((x2 * term) >> 30) / 20);
      term = OneQ30 - (((x2 * term) >> 30) / 6);
      s    = (x * term) >> 30;
      q15  = (s + 64'd16384) >> 15;
      if (q15 > Q15Max) begin
         q15 = Q15Max;
      end
      return (quad >= 64'd2) ? SAMPLE_W'(64'd0 - q15) : SAMPLE_W'(q15);
   endfunction

   logic signed [SAMPLE_W-1:0] rom_mem [TABLE_DEPTH];

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
      assign rom_mem[g] = sine_entry(64'(g));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= rom_mem[addr];
      end
   end

endmodule

// ===== rtl/core/csyn_note_ctrl.sv =====
// ----------------------------------------------------------------------------
// Note control
// Control registers, phase accumulators, note length and sample counter.
// ----------------------------------------------------------------------------
module csyn_note_ctrl
   import csyn_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  csr_index_type                     csr_index,
   input  logic [CSR_W-1:0]                  csr_wdata,
   input  logic                              advance,
   input  logic                              accept,
   input  req_word_type                      req_word,
   output logic [VOLUME_W-1:0]               volume_ff,
   output stage_flags_type                   s1_flags_ff,
   output logic [VOICES-1:0][PHASE_BITS-1:0] s1_phase_ff
);

   logic [SILENCE_W-1:0]                silence_ff;
   logic [VOICES-1:0][PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [VOICES-1:0][PHASE_BITS-1:0]   step_ff, step_in;
   logic [LENGTH_W-1:0]                 length_ff, length_in;
   logic [LENGTH_W-1:0]                 count_ff, count_in;
   stage_flags_type                     s1_flags_in;
   logic                                gate, over;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= VOLUME_RESET;
         silence_ff <= SILENCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VOLUME:  volume_ff  <= csr_wdata[VOLUME_W-1:0];
            CSR_SILENCE: silence_ff <= csr_wdata[SILENCE_W-1:0];
            default:     volume_ff  <= volume_ff;
         endcase
      end
   end

   // The tone plays while count plus silence is below the note length.
   assign gate = ({1'b0, count_ff} + {1'b0, silence_ff}) < {1'b0, length_ff};
   assign over = count_ff >= length_ff;

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      s1_flags_in = '{valid: 1'b0, gate: gate, over: over};
      if (accept) begin
         if (req_word.operation == OP_LOAD) begin
            step_in[0] = req_word.step_first[PHASE_BITS-1:0];
            step_in[1] = req_word.step_second[PHASE_BITS-1:0];
            step_in[2] = req_word.step_third[PHASE_BITS-1:0];
            phase_in   = '0;
            length_in  = req_word.note_length;
            count_in   = '0;
         end else begin
            s1_flags_in.valid = 1'b1;
            if (gate) begin
               for (int v = 0; v < VOICES; v++) begin
                  phase_in[v] = phase_ff[v] + step_ff[v];
               end
            end
            if (!over) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         step_ff     <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         s1_flags_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         if (advance) begin
            s1_flags_ff <= s1_flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_phase_ff <= phase_ff;
      end
   end

endmodule

// ===== rtl/core/csyn_voice_mix.sv =====
// ----------------------------------------------------------------------------
// Voice mixer
// Table lookup, scaling, three-voice sum and division by three times 2^15.
// ----------------------------------------------------------------------------
module csyn_voice_mix
   import csyn_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int PHASE_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [VOLUME_W-1:0]               volume,
   input  stage_flags_type                   s1_flags,
   input  logic [VOICES-1:0][PHASE_BITS-1:0] s1_phase,
   output logic                              rsp_valid_ff,
   output rsp_word_type                      rsp_word_ff
);

   localparam int AddrW  = $clog2(TABLE_DEPTH);
   localparam int IdxW   = PHASE_BITS + AddrW + 1;
   localparam int ProdW  = 2 * SAMPLE_W;
   localparam int SumW   = ProdW + 2;
   localparam int QuotW  = 17;
   localparam int RecipW = 2 * QuotW;
   localparam logic [QuotW-1:0] DivThreeRecip = 17'd87382;

   logic [VOICES-1:0][AddrW-1:0]           rom_addr;
   logic signed [SAMPLE_W-1:0]             sine [VOICES];
   stage_flags_type                        s2_flags_ff, s3_flags_ff, s4_flags_ff, s5_flags_ff;
   logic signed [ProdW-1:0]                s3_prod_ff [VOICES];
   logic signed [SumW-1:0]                 s4_sum_ff;
   logic signed [SumW-1:0]                 sum_in;
   logic [SumW-1:0]                        mag;
   logic                                   s5_neg_ff;
   logic [QuotW-1:0]                       s5_quot_ff;
   logic [RecipW-1:0]                      recip_prod;
   logic [SAMPLE_W-1:0]                    third;
   rsp_word_type                           rsp_word_in;

   for (genvar v = 0; v < VOICES; v++) begin : g_voice
      logic [IdxW-1:0] scaled;
      assign scaled      = IdxW'(s1_phase[v]) * IdxW'(TABLE_DEPTH);
      assign rom_addr[v] = scaled[PHASE_BITS +: AddrW];

      csyn_sine_rom #(
         .TABLE_DEPTH (TABLE_DEPTH)
      ) u_rom (
         .clock      (clock),
         .enable     (advance),
         .addr       (rom_addr[v]),
         .rd_data_ff (sine[v])
      );

      always_ff @(posedge clock) begin
         if (advance) begin
            s3_prod_ff[v] <= s2_flags_ff.gate ?
               ProdW'($signed({1'b0, volume}) * sine[v]) : '0;
         end
      end
   end

   assign sum_in = SumW'(s3_prod_ff[0]) + SumW'(s3_prod_ff[1]) + SumW'(s3_prod_ff[2]);
   assign mag    = s4_sum_ff[SumW-1] ? (SumW'(0) - s4_sum_ff) : s4_sum_ff;

   // Quotient by three through the reciprocal, exact below 2^17.
   assign recip_prod = RecipW'(s5_quot_ff) * RecipW'(DivThreeRecip);
   assign third      = recip_prod[18 +: SAMPLE_W];

   always_comb begin
      rsp_word_in.sample    = s5_neg_ff ? (SAMPLE_W'(0) - third) : third;
      rsp_word_in.note_over = s5_flags_ff.over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_flags_ff  <= '0;
         s3_flags_ff  <= '0;
         s4_flags_ff  <= '0;
         s5_flags_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_flags_ff  <= s1_flags;
         s3_flags_ff  <= s2_flags_ff;
         s4_flags_ff  <= s3_flags_ff;
         s5_flags_ff  <= s4_flags_ff;
         rsp_valid_ff <= s5_flags_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_sum_ff   <= sum_in;
         s5_neg_ff   <= s4_sum_ff[SumW-1];
         s5_quot_ff  <= mag[15 +: QuotW];
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== rtl/core/chord_tone_synthesizer.sv =====
// ----------------------------------------------------------------------------
// Chord tone synthesizer
// Three-voice table-lookup sine oscillator with note gating.
// ----------------------------------------------------------------------------
// The block takes one word per clock while no response is stalled. A load
// word sets the three phase steps and the note length and gives no
// response; a tick word gives one sample. Throughput is set by the phase
// accumulator update, which completes in the accept cycle, while the sample
// itself runs through a six-register pipeline: phase capture, three
// registered copies of the TABLE_DEPTH sine table, scaling, sum, magnitude
// and division by three. The whole pipeline holds while a response waits.
// ----------------------------------------------------------------------------
module chord_tone_synthesizer
   import csyn_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int PHASE_BITS  = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_word
);

   logic                              advance;
   logic [VOLUME_W-1:0]               volume;
   stage_flags_type                   s1_flags;
   logic [VOICES-1:0][PHASE_BITS-1:0] s1_phase;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   csyn_note_ctrl #(
      .PHASE_BITS (PHASE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .advance     (advance),
      .accept      (req_valid && req_ready),
      .req_word    (req_word),
      .volume_ff   (volume),
      .s1_flags_ff (s1_flags),
      .s1_phase_ff (s1_phase)
   );

   csyn_voice_mix #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PHASE_BITS  (PHASE_BITS)
   ) u_mix (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .volume       (volume),
      .s1_flags     (s1_flags),
      .s1_phase     (s1_phase),
      .rsp_valid_ff (rsp_valid),
      .rsp_word_ff  (rsp_word)
   );

endmodule

// ===== rtl/core/csyn_checker.sv =====
// ----------------------------------------------------------------------------
// Chord tone synthesizer checker
// Port-level properties of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "chord_tone_synthesizer_assert.svh"

module csyn_checker
   import csyn_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   `CSYN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled response word changed")

   `CSYN_ASSERT_SAME(a_over_silent, clock, reset, rsp_valid && rsp_word.note_over, rsp_word.sample == '0, "finished note gave a nonzero sample")

   `CSYN_ASSERT_SAME(a_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready, "input stalled with the output free")

   `CSYN_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

   `CSYN_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready && req_valid, !req_ready, "word accepted while the output was stalled")

endmodule

bind chord_tone_synthesizer csyn_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chord tone synthesizer testbench
// A set of test tasks drives load and tick words into the oscillator. A
// predictor inside the bench works out the sample and the note-over flag for
// every accepted tick. The predictor keeps its own copy of the three phase
// accumulators, the note counter, the control registers and the sine table.
// A monitor checks each response word against the oldest prediction; both
// channels stall at random except in the last random run. Directed corner
// cases come first, then long random note runs at several register settings.
// ----------------------------------------------------------------------------
module tb_top;
   import csyn_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam int PHASE_BITS  = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 275;

   logic             clock;
   logic             reset;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [CSR_W-1:0] csr_wdata;
   logic             req_valid;
   logic             req_ready;
   req_word_type     req_word;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_word_type     rsp_word;

   logic signed [SAMPLE_W-1:0] sine_q15_rom [TABLE_DEPTH];
   logic [STEP_W-1:0]          osc_phase [VOICES];
   logic [STEP_W-1:0]          osc_step [VOICES];
   int                         note_len;
   int                         tick_count;
   int                         gain;
   int                         silence_len;

   rsp_word_type pending_samples [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           bursts_on = 1'b1;
   int           stall_left = 0;

   chord_tone_synthesizer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] sine_q15(input int unsigned i);
      longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned n, t, quad, rem, r, x, x2, term, s, q15;
      logic signed [SAMPLE_W-1:0] mag;
      n = TABLE_DEPTH;
      t = longint'(i) * 4;
      quad = t / n;
      rem = t % n;
      r = quad[0] ? (n - rem) : rem;
      x = (r * 64'd1686629713) / n;
      x2 = (x * x) >> 30;
      term = 64'd1073741824;
      for (int k = 0; k < 6; k++)
         term = 64'd1073741824 - (((x2 * term) >> 30) / divs[k]);
      s = (x * term) >> 30;
      q15 = (s + 64'd16384) >> 15;
      if (q15 > 64'd32767)
         q15 = 64'd32767;
      mag = q15[SAMPLE_W-1:0];
      return (quad >= 2) ? -mag : mag;
   endfunction

   task automatic predict_word(input req_word_type w);
      longint tone_end;
      longint acc;
      longint unsigned idx;
      rsp_word_type r;
      if (w.operation == OP_LOAD) begin
         osc_step[0] = w.step_first;
         osc_step[1] = w.step_second;
         osc_step[2] = w.step_third;
         for (int v = 0; v < VOICES; v++)
            osc_phase[v] = '0;
         note_len = w.note_length;
         tick_count = 0;
      end else begin
         tone_end = longint'(note_len) - longint'(silence_len);
         acc = 0;
         r.note_over = 1'b0;
         if (longint'(tick_count) < tone_end) begin
            for (int v = 0; v < VOICES; v++) begin
               idx = ({32'd0, osc_phase[v]} * TABLE_DEPTH) >> PHASE_BITS;
               acc += longint'(gain) * longint'(sine_q15_rom[idx]);
               osc_phase[v] = osc_phase[v] + osc_step[v];
            end
            acc = acc / 98304;
         end else if (tick_count >= note_len) begin
            r.note_over = 1'b1;
         end
         if (tick_count < note_len)
            tick_count++;
         r.sample = acc[SAMPLE_W-1:0];
         pending_samples.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected word: sample %0d, note_over %0b",
                   rsp_word.sample, rsp_word.note_over);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_word.sample !== want.sample) begin
               $error("sample: expected %0d, got %0d", want.sample, rsp_word.sample);
               mismatch_count++;
            end
            if (rsp_word.note_over !== want.note_over) begin
               $error("note_over: expected %0b, got %0b",
                      want.note_over, rsp_word.note_over);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input req_word_type w);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      predict_word(w);
   endtask

   task automatic release_bus;
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_VOLUME:  gain = data[VOLUME_W-1:0];
         CSR_SILENCE: silence_len = data[SILENCE_W-1:0];
         default:     gain = gain;
      endcase
   endtask

   task automatic set_registers(input logic [CSR_W-1:0] vol, input logic [CSR_W-1:0] sil);
      wait_idle();
      write_reg(CSR_VOLUME, vol);
      write_reg(CSR_SILENCE, sil);
      csr_we <= 1'b0;
   endtask

   function automatic logic [STEP_W-1:0] random_step;
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1 << 24);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type make_load(input logic [STEP_W-1:0] a,
                                              input logic [STEP_W-1:0] b,
                                              input logic [STEP_W-1:0] c,
                                              input logic [LENGTH_W-1:0] len);
      req_word_type w;
      w.operation = OP_LOAD;
      w.step_first = a;
      w.step_second = b;
      w.step_third = c;
      w.note_length = len;
      return w;
   endfunction

   function automatic req_word_type make_tick;
      req_word_type w;
      w = make_load($urandom, $urandom, $urandom, LENGTH_W'($urandom));
      w.operation = OP_TICK;
      return w;
   endfunction

   task automatic test_tick_before_load;
      repeat (2) send_word(make_tick());
      release_bus();
   endtask

   // Quarter-turn steps walk every voice through zero, both peaks and zero.
   task automatic test_full_scale_chord;
      set_registers(16'd32767, 16'd2);
      send_word(make_load(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 16'd7));
      repeat (8) send_word(make_tick());
      release_bus();
   endtask

   task automatic test_short_notes;
      set_registers(16'd20000, 16'd3);
      send_word(make_load(random_step(), random_step(), random_step(), 16'd3));
      repeat (2) send_word(make_tick());
      send_word(make_load(random_step(), random_step(), random_step(), 16'd2));
      send_word(make_tick());
      send_word(make_load(random_step(), random_step(), random_step(), 16'd0));
      repeat (2) send_word(make_tick());
      release_bus();
   endtask

   task automatic test_step_extremes;
      set_registers(16'd1, 16'd0);
      send_word(make_load(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF));
      repeat (4) send_word(make_tick());
      release_bus();
   endtask

   task automatic test_random_notes(input int phase_idx);
      int sent;
      int len;
      int ticks;
      logic [CSR_W-1:0] vol;
      logic [CSR_W-1:0] sil;
      case (phase_idx)
         0: begin vol = 16'd32767; sil = 16'd0; end
         1: begin vol = 16'd0; sil = 16'd65535; end
         2: begin
            vol = CSR_W'($urandom_range(0, 65535));
            sil = CSR_W'($urandom_range(0, 8));
         end
         3: begin
            vol = CSR_W'($urandom_range(0, 65535));
            sil = CSR_W'($urandom_range(0, 65535));
         end
         4: begin
            vol = CSR_W'($urandom_range(0, 32767));
            sil = CSR_W'($urandom_range(0, 12));
         end
         default: begin vol = 16'd3000; sil = 16'd5; end
      endcase
      set_registers(vol, sil);
      sent = 0;
      len = 0;
      while (sent < WORDS_PER_PHASE) begin
         if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(0, 65535);
               1, 2:    len = $urandom_range(0, 200);
               default: len = $urandom_range(0, 24);
            endcase
            send_word(make_load(random_step(), random_step(), random_step(),
                                LENGTH_W'(len)));
            sent++;
         end
         ticks = $urandom_range(0, (len < 54 ? len : 54) + 6);
         repeat (ticks) begin
            send_word(make_tick());
            sent++;
         end
      end
      release_bus();
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_VOLUME;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_word <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         sine_q15_rom[i] = sine_q15(i);
      for (int v = 0; v < VOICES; v++) begin
         osc_phase[v] = '0;
         osc_step[v] = '0;
      end
      note_len = 0;
      tick_count = 0;
      gain = VOLUME_RESET;
      silence_len = SILENCE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_tick_before_load();
      test_full_scale_chord();
      test_short_notes();
      test_step_extremes();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1)
            bursts_on = 1'b0;
         test_random_notes(p);
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
